/* hw/rtl/fpr_pkg.sv */
// Shared types and constants for the FIFO page replacement unit.
// Used by fpr_cell, fpr_table and fifo_page_replacement_unit; no dependencies.
`default_nettype none

package fpr_pkg;

  // Built depth of the resident table and width of a page number.
  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;

  // Index width of one frame, and width of a count that can hold MAX_FRAMES.
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  // Configuration register file.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int TSIZE_W    = 5;
  localparam logic [TSIZE_W-1:0] TSIZE_RESET = TSIZE_W'(16);
  localparam logic REG_TABLE_SIZE = 1'b0;

  // Result counters.
  localparam int TOTAL_W = 32;

  // Stream words.
  localparam int S_DATA_W = ((PAGE_BITS + 7) / 8) * 8;
  localparam int M_BITS   = 1 + 2 * TOTAL_W;
  localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [TOTAL_W-1:0]   total_t;

  // A lookup request handed from the top level to the table.
  typedef struct packed {
    logic  valid;
    page_t page;
  } fpr_req_t;

  // Control broadcast by the table to every cell in the chain.
  typedef struct packed {
    logic  miss;
    page_t page;
    cnt_t  used;
    cnt_t  size;
  } fpr_cell_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/fpr_cell.sv */
// One frame of the resident table: holds a page, compares it with the request
// and loads from its younger neighbor or from the request. Depends on fpr_pkg.
`default_nettype none

module fpr_cell (
  input  wire logic                  clk,
  input  wire fpr_pkg::idx_t         cell_index,
  input  wire fpr_pkg::fpr_cell_ctl_t ctl,
  input  wire fpr_pkg::page_t        neighbor,
  output fpr_pkg::page_t             entry,
  output logic                       match
);
  import fpr_pkg::*;

  cnt_t  pos;
  cnt_t  pos_plus;
  logic  load;
  page_t entry_next;

  assign pos      = cnt_t'(cell_index);
  assign pos_plus = pos + cnt_t'(1);

  // Only frames that hold a written page take part in the compare.
  assign match = (pos < ctl.used) && (entry == ctl.page);

  // On a miss the new page fills the next free frame, or the chain moves one
  // place toward the old end and the page enters at the young end.
  always_comb begin
    load       = 1'b0;
    entry_next = ctl.page;
    if (ctl.miss) begin
      if (ctl.used < ctl.size) begin
        load = (pos == ctl.used);
      end else if (pos_plus < ctl.size) begin
        load       = 1'b1;
        entry_next = neighbor;
      end else if (pos_plus == ctl.size) begin
        load = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry <= entry_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fpr_table.sv */
// Resident page table: a chain of fpr_cell frames plus the fill count.
// Depends on fpr_pkg and fpr_cell.
`default_nettype none

module fpr_table (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fpr_pkg::fpr_req_t req,
  input  wire fpr_pkg::cnt_t     size,
  output logic                   hit
);
  import fpr_pkg::*;

  cnt_t          filled_count;
  cnt_t          filled_count_next;
  cnt_t          used;
  fpr_cell_ctl_t ctl;
  page_t         entries [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] cell_match;

  // Frames above the current size are not used, even if filled earlier.
  assign used = (filled_count < size) ? filled_count : size;

  assign hit      = |cell_match;
  assign ctl.miss = req.valid && !hit;
  assign ctl.page = req.page;
  assign ctl.used = used;
  assign ctl.size = size;

  // Chain of frames; the last frame of the chain takes the request as its neighbor.
  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    page_t neighbor;
    if (g < MAX_FRAMES - 1) begin : g_mid
      assign neighbor = entries[g+1];
    end else begin : g_last
      assign neighbor = req.page;
    end

    fpr_cell u_cell (
      .clk        (clk),
      .cell_index (idx_t'(g)),
      .ctl        (ctl),
      .neighbor   (neighbor),
      .entry      (entries[g]),
      .match      (cell_match[g])
    );
  end

  // Fill count grows on a miss until the table is full, then sits at the size.
  always_comb begin
    filled_count_next = filled_count;
    if (ctl.miss) begin
      filled_count_next = (used < size) ? used + cnt_t'(1) : size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled_count <= '0;
    end else begin
      filled_count <= filled_count_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fifo_page_replacement_unit.sv */
// FIFO page replacement unit: stream ports, APB register, counters, result
// register. Depends on fpr_pkg and fpr_table.
//
// Usage:
//   The slave stream takes one page number per word on s_tdata. Page zero is
//   taken and dropped with no result. Every nonzero page is looked up in the
//   resident table; the master stream returns one word per such page with
//   the fault flag and the saturating request and miss totals.
//   The result of an accepted page is registered and shows on m_tvalid in the
//   next cycle. One word is taken per cycle while the receiver keeps up: all
//   frames compare in parallel and the chain of frames shifts in the same
//   cycle, so the compare-and-update across the cells sets the rate.
//   The result sits in an output register. While m_tvalid is high and
//   m_tready is low, s_tready is low; when the result is taken, a new word
//   may be taken in the same cycle.
//   table_size (register 0, byte address 0) selects how many frames are used;
//   zero counts as one and values above the built depth as the full depth.
//   Write it only while the block is idle.
//   Reset clears the fill count, both totals and the output valid flag and sets
//   table_size to 16. No clearing pass runs; the block is ready right after.
`default_nettype none

module fifo_page_replacement_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Slave stream.
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [fpr_pkg::S_DATA_W-1:0]  s_tdata,  // [15:0] page_number
  // Master stream.
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [fpr_pkg::M_DATA_W-1:0]       m_tdata,  // [0] fault,
                                                       // [32:1] request_total,
                                                       // [64:33] miss_total
  // APB configuration port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fpr_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [fpr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [fpr_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import fpr_pkg::*;

  logic [TSIZE_W-1:0] table_size;
  cnt_t     eff_size;
  logic     s_accept;
  logic     cfg_write;
  page_t    page;
  fpr_req_t req;
  logic     hit;
  total_t   request_counter;
  total_t   miss_counter;
  total_t   request_counter_next;
  total_t   miss_counter_next;

  // Register access: register index is the word address.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TSIZE_RESET;
    end else if (cfg_write && (paddr[2] == REG_TABLE_SIZE)) begin
      table_size <= pwdata[TSIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TABLE_SIZE) begin
      prdata = CFG_DATA_W'(table_size);
    end
  end

  // Effective number of frames: zero counts as one, clamp at built depth.
  always_comb begin
    if (table_size == '0) begin
      eff_size = cnt_t'(1);
    end else if (32'(table_size) > 32'(MAX_FRAMES)) begin
      eff_size = cnt_t'(MAX_FRAMES);
    end else begin
      eff_size = cnt_t'(table_size);
    end
  end

  // Input handshake; the output register frees up when its word is taken.
  assign s_tready  = !m_tvalid || m_tready;
  assign s_accept  = s_tvalid && s_tready;
  assign page      = s_tdata[PAGE_BITS-1:0];
  assign req.valid = s_accept && (page != '0);
  assign req.page  = page;

  fpr_table u_table (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .size (eff_size),
    .hit  (hit)
  );

  // Saturating totals.
  always_comb begin
    request_counter_next = request_counter;
    miss_counter_next    = miss_counter;
    if (req.valid) begin
      if (request_counter != '1) begin
        request_counter_next = request_counter + total_t'(1);
      end
      if (!hit && (miss_counter != '1)) begin
        miss_counter_next = miss_counter + total_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      request_counter <= '0;
      miss_counter    <= '0;
    end else begin
      request_counter <= request_counter_next;
      miss_counter    <= miss_counter_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (req.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      m_tdata <= M_DATA_W'({miss_counter_next, request_counter_next, !hit});
    end
  end

  // A zero page never produces a result word.
  a_zero_page_silent: assert property (@(posedge clk) disable iff (rst)
    (s_accept && (page == '0)) |=> !m_tvalid)
    else $error("zero page produced a result word");

  // Every nonzero page produces a result word in the next cycle.
  a_request_result: assert property (@(posedge clk) disable iff (rst)
    req.valid |=> (m_tvalid && (m_tdata[TOTAL_W:1] == request_counter)))
    else $error("request did not produce a matching result word");

  // Misses never outnumber requests.
  a_miss_le_request: assert property (@(posedge clk) disable iff (rst)
    miss_counter <= request_counter)
    else $error("miss total exceeds request total");

endmodule

`default_nettype wire

/* sim/fpr_lookup_checker.sv */
// Checker for the FIFO page replacement unit: watches the page and result
// streams and the APB port, predicts every lookup and compares the results.
// Depends on fpr_pkg for widths, types and the register index.
`timescale 1ns / 1ps

module fpr_lookup_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  input  wire logic                            s_tready,
  input  wire logic [fpr_pkg::S_DATA_W-1:0]    s_tdata,  // [15:0] page_number
  input  wire logic                            m_tvalid,
  input  wire logic                            m_tready,
  input  wire logic [fpr_pkg::M_DATA_W-1:0]    m_tdata,  // [0] fault,
                                                         // [32:1] request_total,
                                                         // [64:33] miss_total
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fpr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [fpr_pkg::CFG_DATA_W-1:0]  pwdata,
  input  wire logic [fpr_pkg::CFG_DATA_W-1:0]  prdata,
  input  wire logic                            pready,
  output int                                   mismatch_count,
  output int                                   pending_results
);
  import fpr_pkg::*;

  typedef struct packed {
    logic   fault;
    total_t request_total;
    total_t miss_total;
  } lookup_result_t;

  // Shadow copy of the resident table, its fill level and the totals.
  page_t              frames [MAX_FRAMES];
  int                 fill_count;
  logic [TSIZE_W-1:0] table_size_q;
  total_t             request_count;
  total_t             miss_count;
  lookup_result_t     lookup_queue [$];

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  // Looks up one nonzero page, updates the shadow table and returns the word
  // the block should produce for it.
  function automatic lookup_result_t predict_lookup(input page_t pg);
    lookup_result_t res;
    int             eff;
    int             used;
    logic           hit;
    // Zero counts as one frame, anything above the built depth as the depth.
    eff = (table_size_q == '0) ? 1 :
          ((table_size_q > MAX_FRAMES) ? MAX_FRAMES : int'(table_size_q));
    used = (fill_count < eff) ? fill_count : eff;
    hit = 1'b0;
    for (int i = 0; i < used; i++) begin
      if (frames[i] == pg) hit = 1'b1;
    end
    if (request_count != '1) request_count = request_count + 1'b1;
    if (!hit) begin
      if (miss_count != '1) miss_count = miss_count + 1'b1;
      if (used < eff) begin
        frames[used] = pg;
        fill_count = used + 1;
      end else begin
        // Table full: drop the oldest and append at the young end.
        for (int i = 0; i + 1 < eff; i++) frames[i] = frames[i + 1];
        frames[eff - 1] = pg;
        fill_count = eff;
      end
    end
    res.fault         = !hit;
    res.request_total = request_count;
    res.miss_total    = miss_count;
    return res;
  endfunction

  // Results are checked before the same edge's new page is predicted, since
  // a result always belongs to an earlier word.
  always @(posedge clk) begin : monitor
    lookup_result_t got;
    lookup_result_t want;
    if (rst) begin
      fill_count    = 0;
      request_count = '0;
      miss_count    = '0;
      table_size_q  = TSIZE_RESET;
      lookup_queue.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.fault         = m_tdata[0];
        got.request_total = m_tdata[TOTAL_W:1];
        got.miss_total    = m_tdata[2*TOTAL_W:TOTAL_W+1];
        if (lookup_queue.size() == 0) begin
          $display("%0t: result word with none expected: fault=%0b requests=%0d misses=%0d",
                   $time, got.fault, got.request_total, got.miss_total);
          mismatch_count++;
        end else begin
          want = lookup_queue.pop_front();
          if (got.fault !== want.fault || got.request_total !== want.request_total ||
              got.miss_total !== want.miss_total) begin
            $display("%0t: result mismatch: expected fault=%0b requests=%0d misses=%0d, got fault=%0b requests=%0d misses=%0d",
                     $time, want.fault, want.request_total, want.miss_total,
                     got.fault, got.request_total, got.miss_total);
            mismatch_count++;
          end
        end
      end
      // Page zero is dropped by the block without a result.
      if (s_tvalid && s_tready && s_tdata[PAGE_BITS-1:0] != '0) begin
        lookup_queue.push_back(predict_lookup(s_tdata[PAGE_BITS-1:0]));
      end
      // Register access; writes to other indexes are ignored.
      if (psel && penable && pready) begin
        if (paddr[CFG_ADDR_W-1:2] == REG_TABLE_SIZE) begin
          if (pwrite) begin
            table_size_q = pwdata[TSIZE_W-1:0];
          end else if (prdata !== CFG_DATA_W'(table_size_q)) begin
            $display("%0t: table_size read mismatch: expected %0d, got %0d",
                     $time, table_size_q, prdata);
            mismatch_count++;
          end
        end
      end
    end
    pending_results = lookup_queue.size();
  end

endmodule

/* sim/tb_fifo_page_replacement_unit.sv */
// Top of the FIFO page replacement unit testbench: clock, reset, page and APB
// stimulus, receiver stalls and verdict. Depends on fpr_pkg, the block and
// fpr_lookup_checker.
`timescale 1ns / 1ps

module tb_fifo_page_replacement_unit;
  import fpr_pkg::*;

  localparam int STALL_LIMIT    = 2000;
  localparam int PHASE_WORDS    = 105;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PRESSURE_PHASE = 3;
  localparam int LONG_HOLD      = 64;
  localparam int NUM_PHASES     = 9;
  localparam logic [CFG_ADDR_W-1:0] ADDR_TABLE_SIZE =
    CFG_ADDR_W'({REG_TABLE_SIZE, 2'b00});
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED =
    CFG_ADDR_W'({~REG_TABLE_SIZE, 2'b00});

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatch_count;
  int pending_results;
  int quiet_cycles = 0;
  int hold_request = 0;
  int hold_len;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  // Table sizes per phase: shrinking from a full table, zero, values above
  // the depth, and growing again.
  int unsigned phase_sizes [NUM_PHASES] = '{1, 4, 0, 16, 31, 17, 2, 9, 16};

  // Directed words: extreme pages, fill to sixteen frames, evict, hit and
  // miss on evicted pages, with page zero in between.
  page_t directed_pages [24] = '{
    16'h0001, 16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA,
    16'h0003, 16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'h0008, 16'h0009, 16'h000A,
    16'h000B, 16'h000C, 16'h000D, 16'h000E, 16'h0001, 16'h8000, 16'h0000, 16'h000E};

  fifo_page_replacement_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  fpr_lookup_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random short stalls, or one long hold when requested.
  always begin
    @(negedge clk);
    if (hold_request > 0) begin
      hold_len = hold_request;
      hold_request = 0;
      m_tready <= 1'b0;
      repeat (hold_len) @(negedge clk);
      m_tready <= 1'b1;
    end else if (rx_idle && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
      m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles in which no word and no register access is taken.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offers one page word, with an optional gap first, and returns at the
  // falling edge after it was taken.
  task automatic send_page(input page_t pg);
    int gap;
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_DATA_W'(pg);
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // One APB transfer: setup phase, access phase, then idle with psel low.
  task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Stops offering words and waits until every result is in and the block
  // has had time to finish a trailing page zero.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly pages from a small pool so that hits and evictions both occur,
  // some fully random pages, and the odd page zero.
  function automatic page_t pick_page(input page_t base, input int span);
    int    roll;
    page_t pg;
    roll = $urandom_range(0, 99);
    if (roll < 3) pg = '0;
    else if (roll < 15) pg = page_t'($urandom_range(1, 65535));
    else pg = base + page_t'($urandom_range(0, span - 1));
    return pg;
  endfunction

  initial begin : stimulus
    int    eff;
    int    span;
    page_t base;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Reset value of the register, then the directed words at full size.
    apb_access(1'b0, ADDR_TABLE_SIZE, '0);
    foreach (directed_pages[i]) send_page(directed_pages[i]);
    drain();

    // Random phases, one table size each; the last one runs without gaps.
    for (int p = 0; p < NUM_PHASES; p++) begin
      tx_idle = (p != NUM_PHASES - 1) && (p != PRESSURE_PHASE);
      rx_idle = (p != NUM_PHASES - 1);
      apb_access(1'b1, ADDR_TABLE_SIZE, ($urandom & ~32'h1F) | phase_sizes[p]);
      if (p == 2) apb_access(1'b1, ADDR_UNMAPPED, $urandom);
      apb_access(1'b0, ADDR_TABLE_SIZE, '0);
      if (p == PRESSURE_PHASE) hold_request = LONG_HOLD;
      eff  = (phase_sizes[p] == 0) ? 1 :
             ((phase_sizes[p] > MAX_FRAMES) ? MAX_FRAMES : int'(phase_sizes[p]));
      span = eff + $urandom_range(1, eff / 2 + 2);
      base = page_t'($urandom_range(1, 65535 - 40));
      repeat (PHASE_WORDS) send_page(pick_page(base, span));
      drain();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
